// ===== sv/sorted_priority_queue_with_key_delete_unit_macros.svh =====
// assertion macros for the sorted priority queue unit
// expects signals named clock and reset in the scope of each use
`ifndef SORTED_PRIORITY_QUEUE_WITH_KEY_DELETE_UNIT_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_WITH_KEY_DELETE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define SPQKD_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("spqkd: same-cycle check failed");

// next-cycle implication
`define SPQKD_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("spqkd: next-cycle check failed");

`else

`define SPQKD_ASSERT_IMPL(name, ante, cons)
`define SPQKD_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// ===== sv/spqkd_pkg.sv =====
// shared types and constants of the sorted priority queue unit
// no dependencies
package spqkd_pkg;

   localparam int CAPACITY_DEF    = 64;
   localparam int WEIGHT_BITS_DEF = 16;
   localparam int VERTEX_BITS_DEF = 8;

   localparam int ACTION_BITS = 2;
   localparam int STATUS_BITS = 3;

   localparam logic [ACTION_BITS-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_POP    = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_REMOVE = 2'd2;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK       = 3'd0,
      ST_ZERO     = 3'd1,
      ST_FULL     = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_code_type;

   // read address source
   typedef enum logic [1:0] {
      RD_ZERO,
      RD_IDX,
      RD_IDX_DEC,
      RD_IDX_INC
   } rd_sel_type;

   // index register update
   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_CLEAR,
      IDX_LOAD_COUNT,
      IDX_INC,
      IDX_DEC
   } idx_op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_INS_RD,
      S_INS_CHK,
      S_INS_PUT,
      S_REM_RD,
      S_REM_CHK,
      S_SHF_RD,
      S_SHF_WR,
      S_HEAD_RD,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic            latch_req;
      logic            rd_en;
      rd_sel_type      rd_sel;
      logic            wr_en;
      logic            wr_new;
      idx_op_type      idx_op;
      logic            cnt_inc;
      logic            cnt_dec;
      logic            status_we;
      status_code_type status_val;
      logic            load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic is_insert;
      logic is_pop;
      logic is_remove;
      logic zero_weight;
      logic empty;
      logic full;
      logic rd_greater;
      logic rd_match;
      logic idx_one;
      logic idx_last;
      logic rsp_busy;
   } dp_stat_type;

endpackage

// ===== sv/sorted_priority_queue_with_key_delete_unit.sv =====
// top level of the sorted min-priority queue with delete by vertex
// depends on spqkd_pkg, spqkd_ctrl, spqkd_dpath and the macros header
//
//  channel  dir  handshake                fields
//  req      in   req_tvalid / req_tready  tuser: action; tdata: weight, vertex
//  rsp      out  rsp_tvalid / rsp_tready  tuser: status; tdata: head_weight,
//                                         head_vertex, queue_empty, entry_count
//
// one item at a time, each stepped through the entry memory:
//   insert walks down from the tail, shifting each larger entry up, then writes the new one
//   rejects and no-ops only read the head; pop shifts every later entry down by one
//   remove scans from the head to the first match, then shifts the entries after it down
// the entry memory allows one read and one write a cycle, read registered
// reset is synchronous; the memory itself needs no clearing pass
// a result waits in its output register while the next transfer is accepted,
// and the following result waits for rsp_tready before it takes that register
`include "sorted_priority_queue_with_key_delete_unit_macros.svh"

module sorted_priority_queue_with_key_delete_unit #(
   parameter int CAPACITY    = spqkd_pkg::CAPACITY_DEF,
   parameter int WEIGHT_BITS = spqkd_pkg::WEIGHT_BITS_DEF,
   parameter int VERTEX_BITS = spqkd_pkg::VERTEX_BITS_DEF,
   localparam int CW            = $clog2(CAPACITY + 1),
   localparam int REQ_DATA_BITS = ((WEIGHT_BITS + VERTEX_BITS + 7) / 8) * 8,
   localparam int RSP_DATA_BITS = ((WEIGHT_BITS + VERTEX_BITS + 1 + CW + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // weight, vertex, zero fill
   input  logic [REQ_DATA_BITS-1:0]          req_tdata,
   // action
   input  logic [spqkd_pkg::ACTION_BITS-1:0] req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // head_weight, head_vertex, queue_empty, entry_count, zero fill
   output logic [RSP_DATA_BITS-1:0]          rsp_tdata,
   // status
   output logic [spqkd_pkg::STATUS_BITS-1:0] rsp_tuser
);
   import spqkd_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   logic [WEIGHT_BITS-1:0] rsp_weight;
   logic [VERTEX_BITS-1:0] rsp_vertex;
   logic                   rsp_empty;
   logic [CW-1:0]          rsp_count;

   spqkd_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .stat     (stat),
      .cmd      (cmd)
   );

   spqkd_dpath #(
      .CAPACITY    (CAPACITY),
      .WEIGHT_BITS (WEIGHT_BITS),
      .VERTEX_BITS (VERTEX_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .in_action  (req_tuser),
      .in_weight  (req_tdata[WEIGHT_BITS-1:0]),
      .in_vertex  (req_tdata[WEIGHT_BITS +: VERTEX_BITS]),
      .out_ready  (rsp_tready),
      .out_valid  (rsp_tvalid),
      .out_status (rsp_tuser),
      .out_weight (rsp_weight),
      .out_vertex (rsp_vertex),
      .out_empty  (rsp_empty),
      .out_count  (rsp_count)
   );

   // pack result fields from the lowest bit up
   assign rsp_tdata = RSP_DATA_BITS'({rsp_count, rsp_empty, rsp_vertex, rsp_weight});

   // the count never runs past the capacity
   `SPQKD_ASSERT_IMPL(a_count_bound, rsp_tvalid, rsp_count <= CW'(CAPACITY))
   // empty flag and zeroed head agree with the count
   `SPQKD_ASSERT_IMPL(a_empty_flag, rsp_tvalid,
                      (rsp_empty == (rsp_count == '0)) && (!rsp_empty || rsp_weight == '0))
   // a dropped insert means the queue really is full
   `SPQKD_ASSERT_IMPL(a_full_drop, rsp_tvalid && (rsp_tuser == ST_FULL),
                      rsp_count == CW'(CAPACITY))
   // a transfer in makes the block busy for the next cycle
   `SPQKD_ASSERT_NEXT(a_busy_after_req, req_tvalid && req_tready, !req_tready)

endmodule

// ===== sv/spqkd_dpath.sv =====
// datapath: entry memory, count, scan index, request and result registers
// depends on spqkd_pkg
module spqkd_dpath #(
   parameter int CAPACITY    = spqkd_pkg::CAPACITY_DEF,
   parameter int WEIGHT_BITS = spqkd_pkg::WEIGHT_BITS_DEF,
   parameter int VERTEX_BITS = spqkd_pkg::VERTEX_BITS_DEF,
   localparam int AW = $clog2(CAPACITY),
   localparam int CW = $clog2(CAPACITY + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  spqkd_pkg::dp_cmd_type           cmd,
   output spqkd_pkg::dp_stat_type          stat,
   input  logic [spqkd_pkg::ACTION_BITS-1:0] in_action,
   input  logic [WEIGHT_BITS-1:0]          in_weight,
   input  logic [VERTEX_BITS-1:0]          in_vertex,
   input  logic                            out_ready,
   output logic                            out_valid,
   output logic [spqkd_pkg::STATUS_BITS-1:0] out_status,
   output logic [WEIGHT_BITS-1:0]          out_weight,
   output logic [VERTEX_BITS-1:0]          out_vertex,
   output logic                            out_empty,
   output logic [CW-1:0]                   out_count
);
   import spqkd_pkg::*;

   logic [WEIGHT_BITS-1:0] w_mem [CAPACITY];
   logic [VERTEX_BITS-1:0] v_mem [CAPACITY];

   logic [ACTION_BITS-1:0] action_ff;
   logic [WEIGHT_BITS-1:0] weight_ff;
   logic [VERTEX_BITS-1:0] vertex_ff;
   logic [WEIGHT_BITS-1:0] rd_w_ff;
   logic [VERTEX_BITS-1:0] rd_v_ff;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          idx_ff, idx_in;
   status_code_type        status_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [WEIGHT_BITS-1:0] rsp_w_ff;
   logic [VERTEX_BITS-1:0] rsp_v_ff;
   logic                   rsp_empty_ff;
   logic [CW-1:0]          rsp_count_ff;

   logic [CW-1:0]          rd_idx;
   logic [AW-1:0]          rd_addr, wr_addr;
   logic [WEIGHT_BITS-1:0] wr_w;
   logic [VERTEX_BITS-1:0] wr_v;
   logic [CW:0]            idx_next_wide;

   always_comb begin
      unique case (cmd.rd_sel)
         RD_ZERO:    rd_idx = '0;
         RD_IDX:     rd_idx = idx_ff;
         RD_IDX_DEC: rd_idx = idx_ff - CW'(1);
         RD_IDX_INC: rd_idx = idx_ff + CW'(1);
         default:    rd_idx = '0;
      endcase
   end

   assign rd_addr = rd_idx[AW-1:0];
   assign wr_addr = idx_ff[AW-1:0];
   assign wr_w    = cmd.wr_new ? weight_ff : rd_w_ff;
   assign wr_v    = cmd.wr_new ? vertex_ff : rd_v_ff;

   // entry memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         w_mem[wr_addr] <= wr_w;
         v_mem[wr_addr] <= wr_v;
      end
      if (cmd.rd_en) begin
         rd_w_ff <= w_mem[rd_addr];
         rd_v_ff <= v_mem[rd_addr];
      end
   end

   always_comb begin
      unique case (cmd.idx_op)
         IDX_HOLD:       idx_in = idx_ff;
         IDX_CLEAR:      idx_in = '0;
         IDX_LOAD_COUNT: idx_in = count_ff;
         IDX_INC:        idx_in = idx_ff + CW'(1);
         IDX_DEC:        idx_in = idx_ff - CW'(1);
         default:        idx_in = idx_ff;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      priority if (cmd.cnt_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (out_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.latch_req) begin
         action_ff <= in_action;
         weight_ff <= in_weight;
         vertex_ff <= in_vertex;
         status_ff <= ST_OK;
      end else if (cmd.status_we) begin
         status_ff <= cmd.status_val;
      end
      if (cmd.load_rsp) begin
         rsp_w_ff     <= (count_ff == '0) ? '0 : rd_w_ff;
         rsp_v_ff     <= (count_ff == '0) ? '0 : rd_v_ff;
         rsp_empty_ff <= (count_ff == '0);
         rsp_count_ff <= count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         out_status <= status_ff;
      end
   end

   assign idx_next_wide = {1'b0, idx_ff} + (CW + 1)'(1);

   assign stat.is_insert   = (action_ff == ACT_INSERT);
   assign stat.is_pop      = (action_ff == ACT_POP);
   assign stat.is_remove   = (action_ff == ACT_REMOVE);
   assign stat.zero_weight = (weight_ff == '0);
   assign stat.empty       = (count_ff == '0);
   assign stat.full        = (count_ff == CW'(CAPACITY));
   assign stat.rd_greater  = (rd_w_ff > weight_ff);
   assign stat.rd_match    = (rd_v_ff == vertex_ff);
   assign stat.idx_one     = (idx_ff == CW'(1));
   assign stat.idx_last    = (idx_next_wide >= {1'b0, count_ff});
   assign stat.rsp_busy    = rsp_valid_ff && !out_ready;

   assign out_valid  = rsp_valid_ff;
   assign out_weight = rsp_w_ff;
   assign out_vertex = rsp_v_ff;
   assign out_empty  = rsp_empty_ff;
   assign out_count  = rsp_count_ff;

endmodule

// ===== sv/spqkd_ctrl.sv =====
// controller state machine: sequences scans and shifts over the entry memory
// depends on spqkd_pkg
module spqkd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  spqkd_pkg::dp_stat_type stat,
   output spqkd_pkg::dp_cmd_type  cmd
);
   import spqkd_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      in_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            priority if (stat.is_insert) begin
               priority if (stat.zero_weight) begin
                  cmd.status_we  = 1'b1;
                  cmd.status_val = ST_ZERO;
                  state_in       = S_HEAD_RD;
               end else if (stat.full) begin
                  cmd.status_we  = 1'b1;
                  cmd.status_val = ST_FULL;
                  state_in       = S_HEAD_RD;
               end else begin
                  cmd.idx_op = IDX_LOAD_COUNT;
                  state_in   = stat.empty ? S_INS_PUT : S_INS_RD;
               end
            end else if (stat.is_pop) begin
               if (stat.empty) begin
                  cmd.status_we  = 1'b1;
                  cmd.status_val = ST_EMPTY;
                  state_in       = S_HEAD_RD;
               end else begin
                  cmd.idx_op = IDX_CLEAR;
                  state_in   = S_SHF_RD;
               end
            end else if (stat.is_remove) begin
               if (stat.empty) begin
                  cmd.status_we  = 1'b1;
                  cmd.status_val = ST_NOTFOUND;
                  state_in       = S_HEAD_RD;
               end else begin
                  cmd.idx_op = IDX_CLEAR;
                  state_in   = S_REM_RD;
               end
            end else begin
               state_in = S_HEAD_RD;
            end
         end
         // walk down from the tail, moving larger entries up by one
         S_INS_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_IDX_DEC;
            state_in   = S_INS_CHK;
         end
         S_INS_CHK: begin
            if (stat.rd_greater) begin
               cmd.wr_en  = 1'b1;
               cmd.idx_op = IDX_DEC;
               state_in   = stat.idx_one ? S_INS_PUT : S_INS_RD;
            end else begin
               state_in = S_INS_PUT;
            end
         end
         S_INS_PUT: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_new  = 1'b1;
            cmd.cnt_inc = 1'b1;
            state_in    = S_HEAD_RD;
         end
         // search from the head for the first matching vertex
         S_REM_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_IDX;
            state_in   = S_REM_CHK;
         end
         S_REM_CHK: begin
            priority if (stat.rd_match) begin
               state_in = S_SHF_RD;
            end else if (stat.idx_last) begin
               cmd.status_we  = 1'b1;
               cmd.status_val = ST_NOTFOUND;
               state_in       = S_HEAD_RD;
            end else begin
               cmd.idx_op = IDX_INC;
               state_in   = S_REM_RD;
            end
         end
         // close the gap at idx by moving later entries down
         S_SHF_RD: begin
            if (stat.idx_last) begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_HEAD_RD;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_IDX_INC;
               state_in   = S_SHF_WR;
            end
         end
         S_SHF_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.idx_op = IDX_INC;
            state_in   = S_SHF_RD;
         end
         S_HEAD_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_ZERO;
            state_in   = S_FINISH;
         end
         S_FINISH: begin
            if (!stat.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== test/sorted_priority_queue_with_key_delete_unit_test.sv =====
// self-checking testbench for the sorted priority queue unit
// depends on spqkd_pkg and sorted_priority_queue_with_key_delete_unit
// a local sorted-list predictor forecasts every result, which is compared field by field
module sorted_priority_queue_with_key_delete_unit_test;
   import spqkd_pkg::*;

   localparam int DEPTH = CAPACITY_DEF;
   localparam int WB = WEIGHT_BITS_DEF;
   localparam int VB = VERTEX_BITS_DEF;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int REQ_BITS = ((WB + VB + 7) / 8) * 8;
   localparam int RSP_BITS = ((WB + VB + 1 + CW + 7) / 8) * 8;
   // the one action code with no operation behind it
   localparam logic [ACTION_BITS-1:0] ACT_NOP = 2'd3;
   localparam int ITEM_TOTAL = 1050;
   // cycles that the slowest operation can take, with margin
   localparam int DRAIN_CYCLES = 300;

   typedef struct {
      logic [ACTION_BITS-1:0] act;
      logic [WB-1:0]          weight;
      logic [VB-1:0]          vertex;
      bit                     hold;    // wait until every result is back first
   } request_type;

   typedef struct {
      logic [WB-1:0] weight;
      logic [VB-1:0] vertex;
   } entry_type;

   typedef struct {
      status_code_type status;
      logic [WB-1:0]   head_weight;
      logic [VB-1:0]   head_vertex;
      logic            queue_empty;
      logic [CW-1:0]   entry_count;
   } head_report_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // weight, vertex, zero fill
   logic [REQ_BITS-1:0]    req_tdata = '0;
   // action
   logic [ACTION_BITS-1:0] req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // head_weight, head_vertex, queue_empty, entry_count, zero fill
   logic [RSP_BITS-1:0]    rsp_tdata;
   // status
   logic [STATUS_BITS-1:0] rsp_tuser;

   sorted_priority_queue_with_key_delete_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // predicted queue contents, kept in ascending weight order
   // ---------------------------------------------------------------
   entry_type       sorted_entries[$];
   request_type     req_backlog[$];      // items still to be offered
   head_report_type reports_due[$];      // forecast results, oldest first

   int     sent_count = 0;
   int     accepted = 0;
   int     failures = 0;
   int     action_seen[4] = '{default: 0};
   int     status_seen[8] = '{default: 0};
   int     deepest = 0;
   bit     req_took = 1'b0;              // request transfer at the last rising edge
   int     req_gap = 0;
   int     rsp_stall = 0;
   request_type next_req;
   logic   quiet;

   // no idling in the closing stretch, and none in a window of every 200 items
   assign quiet = ((sent_count % 200) < 40) || (sent_count + 150 >= ITEM_TOTAL);

   // apply one operation to the predicted queue and forecast its result
   function automatic head_report_type predict_outcome(input logic [ACTION_BITS-1:0] act,
                                                       input logic [WB-1:0] w,
                                                       input logic [VB-1:0] v);
      head_report_type r;
      entry_type       e;
      int              pos;
      r.status = ST_OK;
      case (act)
         ACT_INSERT: begin
            if (w == '0) begin
               r.status = ST_ZERO;
            end else if (sorted_entries.size() >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               // after every entry of equal or smaller weight, so ties keep arrival order
               pos = 0;
               while (pos < sorted_entries.size() && sorted_entries[pos].weight <= w)
                  pos++;
               e.weight = w;
               e.vertex = v;
               sorted_entries.insert(pos, e);
            end
         end
         ACT_POP: begin
            if (sorted_entries.size() == 0)
               r.status = ST_EMPTY;
            else
               sorted_entries.delete(0);
         end
         ACT_REMOVE: begin
            r.status = ST_NOTFOUND;
            for (int i = 0; i < sorted_entries.size(); i++) begin
               if (sorted_entries[i].vertex == v) begin
                  sorted_entries.delete(i);
                  r.status = ST_OK;
                  break;
               end
            end
         end
         default: ;
      endcase
      r.entry_count = CW'(sorted_entries.size());
      r.queue_empty = (sorted_entries.size() == 0);
      r.head_weight = r.queue_empty ? '0 : sorted_entries[0].weight;
      r.head_vertex = r.queue_empty ? '0 : sorted_entries[0].vertex;
      return r;
   endfunction

   task automatic report_mismatch(input string field, input longint want, input longint got);
      $error("%s: expected %0d, actual %0d", field, want, got);
      failures++;
   endtask

   // ---------------------------------------------------------------
   // monitor: sample both channels at the rising edge
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      head_report_type want;
      if (reset) begin
         req_took <= 1'b0;
      end else begin
         req_took <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            reports_due.push_back(predict_outcome(req_tuser, req_tdata[WB-1:0],
                                                  req_tdata[WB+VB-1:WB]));
            action_seen[req_tuser]++;
            accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (reports_due.size() == 0) begin
               $error("result transfer with nothing expected (status %0d)", rsp_tuser);
               failures++;
            end else begin
               want = reports_due.pop_front();
               if (rsp_tuser !== want.status)
                  report_mismatch("status", want.status, rsp_tuser);
               if (rsp_tdata[WB-1:0] !== want.head_weight)
                  report_mismatch("head_weight", want.head_weight, rsp_tdata[WB-1:0]);
               if (rsp_tdata[WB+VB-1:WB] !== want.head_vertex)
                  report_mismatch("head_vertex", want.head_vertex, rsp_tdata[WB+VB-1:WB]);
               if (rsp_tdata[WB+VB] !== want.queue_empty)
                  report_mismatch("queue_empty", want.queue_empty, rsp_tdata[WB+VB]);
               if (rsp_tdata[WB+VB+CW:WB+VB+1] !== want.entry_count)
                  report_mismatch("entry_count", want.entry_count,
                                  rsp_tdata[WB+VB+CW:WB+VB+1]);
               status_seen[want.status]++;
               if (want.entry_count > deepest)
                  deepest = want.entry_count;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // driver: change inputs at the falling edge
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= '0;
         rsp_tready <= 1'b0;
      end else begin
         // request side: hold the item until its transfer, then move on
         if (!req_tvalid || req_took) begin
            if (req_gap > 0) begin
               req_gap    <= req_gap - 1;
               req_tvalid <= 1'b0;
            end else if (req_backlog.size() > 0 &&
                         !(req_backlog[0].hold && reports_due.size() != 0)) begin
               next_req = req_backlog.pop_front();
               req_tuser  <= next_req.act;
               req_tdata  <= REQ_BITS'({next_req.vertex, next_req.weight});
               req_tvalid <= 1'b1;
               sent_count <= sent_count + 1;
               if (!quiet && $urandom_range(0, 5) == 0)
                  req_gap <= $urandom_range(1, 6);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         // result side: stall in short bursts
         if (rsp_stall > 0) begin
            rsp_stall  <= rsp_stall - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!quiet && $urandom_range(0, 6) == 0)
               rsp_stall <= $urandom_range(1, 6);
         end
      end
   end

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------
   task automatic queue_item(input logic [ACTION_BITS-1:0] act, input int w, input int v,
                             input bit hold = 1'b0);
      request_type t;
      t.act    = act;
      t.weight = w[WB-1:0];
      t.vertex = v[VB-1:0];
      t.hold   = hold;
      req_backlog.push_back(t);
   endtask

   // mostly nonzero, with crowded ties and the extremes now and then
   function automatic int pick_weight(input int zero_pct, input bit crowded);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < zero_pct)
         return 0;
      if (crowded || roll < zero_pct + 15) begin
         case ($urandom_range(0, 5))
            0: return (1 << WB) - 1;
            1: return (1 << WB) - 2;
            default: return $urandom_range(1, 4);
         endcase
      end
      return $urandom_range(1, (1 << WB) - 1);
   endfunction

   // a small vertex pool makes removes find their targets
   function automatic int pick_vertex();
      if ($urandom_range(0, 9) < 6)
         return $urandom_range(0, 15);
      return $urandom_range(0, (1 << VB) - 1);
   endfunction

   initial begin
      int mode;
      int seg_len;
      int roll;
      int item_total;
      // directed: empty-queue cases, zero weight, extremes, ties, no-op code
      queue_item(ACT_POP, 0, 0);
      queue_item(ACT_REMOVE, 0, 0);
      queue_item(ACT_NOP, 16'hFFFF, 8'hFF);
      queue_item(ACT_INSERT, 0, 8'hAA);
      queue_item(ACT_INSERT, 16'hFFFF, 8'hFF);
      queue_item(ACT_INSERT, 16'hFFFF, 8'h00);
      queue_item(ACT_INSERT, 1, 8'h80);
      queue_item(ACT_INSERT, 16'h8000, 8'h01);
      queue_item(ACT_INSERT, 1, 8'h7F);
      queue_item(ACT_INSERT, 16'h8000, 8'hFF);
      queue_item(ACT_REMOVE, 0, 8'hFF);           // first of two matches, mid-queue
      queue_item(ACT_REMOVE, 0, 8'h33);
      queue_item(ACT_NOP, 0, 0);
      queue_item(ACT_POP, 0, 0);
      queue_item(ACT_REMOVE, 0, 8'h7F);           // match at the head
      queue_item(ACT_POP, 0, 0);
      queue_item(ACT_POP, 0, 0);
      queue_item(ACT_POP, 0, 0);
      queue_item(ACT_POP, 0, 0);                  // pop on the emptied queue
      queue_item(ACT_REMOVE, 0, 8'hFF);
      queue_item(ACT_INSERT, 0, 0);

      // fill past capacity once, after letting the block drain
      queue_item(ACT_INSERT, pick_weight(0, 1'b0), pick_vertex(), 1'b1);
      for (int i = 0; i < DEPTH + 3; i++)
         queue_item(ACT_INSERT, pick_weight(0, i % 4 == 0), pick_vertex());

      // random segments: fill, drain, tie-heavy and mixed, each with random content
      while (req_backlog.size() < ITEM_TOTAL) begin
         mode    = $urandom_range(0, 3);
         seg_len = $urandom_range(20, 90);
         for (int i = 0; i < seg_len && req_backlog.size() < ITEM_TOTAL; i++) begin
            roll = $urandom_range(0, 99);
            case (mode)
               0: begin
                  if (roll < 85)
                     queue_item(ACT_INSERT, pick_weight(3, 1'b0), pick_vertex());
                  else
                     queue_item(roll < 93 ? ACT_POP : ACT_REMOVE, 0, pick_vertex());
               end
               1: begin
                  if (roll < 45)
                     queue_item(ACT_POP, $urandom_range(0, (1 << WB) - 1), pick_vertex());
                  else if (roll < 85)
                     queue_item(ACT_REMOVE, $urandom_range(0, (1 << WB) - 1),
                                pick_vertex());
                  else
                     queue_item(ACT_INSERT, pick_weight(5, 1'b0), pick_vertex());
               end
               2: begin
                  if (roll < 60)
                     queue_item(ACT_INSERT, pick_weight(3, 1'b1), $urandom_range(0, 7));
                  else
                     queue_item(roll < 75 ? ACT_POP : ACT_REMOVE, 0,
                                $urandom_range(0, 7));
               end
               default: begin
                  if (roll < 3)
                     queue_item(ACT_NOP, $urandom_range(0, (1 << WB) - 1),
                                $urandom_range(0, (1 << VB) - 1));
                  else if (roll < 50)
                     queue_item(ACT_INSERT, pick_weight(8, 1'b0), pick_vertex());
                  else if (roll < 75)
                     queue_item(ACT_POP, 0, 0);
                  else
                     queue_item(ACT_REMOVE, 0, pick_vertex());
               end
            endcase
         end
         // now and then let everything come back before the next segment
         if ($urandom_range(0, 3) == 0 && req_backlog.size() < ITEM_TOTAL)
            queue_item(ACT_POP, 0, 0, 1'b1);
      end
      item_total = req_backlog.size();

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (accepted == item_total);
      wait (reports_due.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (reports_due.size() != 0) begin
         $error("%0d results never arrived", reports_due.size());
         failures++;
      end

      $display("ran %0d operations: %0d inserts, %0d pops, %0d removes, %0d no-ops",
               accepted, action_seen[ACT_INSERT], action_seen[ACT_POP],
               action_seen[ACT_REMOVE], action_seen[ACT_NOP]);
      $display("statuses ok %0d, zero %0d, full %0d, empty %0d, not found %0d; deepest %0d",
               status_seen[ST_OK], status_seen[ST_ZERO], status_seen[ST_FULL],
               status_seen[ST_EMPTY], status_seen[ST_NOTFOUND], deepest);
      if (failures == 0) begin
         $display("sorted_priority_queue_with_key_delete_unit_test OK");
      end else begin
         $display("sorted_priority_queue_with_key_delete_unit_test NOT OK");
      end
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #16000000;
      $display("sorted_priority_queue_with_key_delete_unit_test NOT OK");
      $finish;
   end

endmodule
